>>> rtl/i2r_pkg.sv
// Package for the integer to Roman numeral converter.
// Holds the shared item type, the ASCII letter codes and the greedy step table.
// No dependencies.
package i2r_pkg;

  localparam int unsigned NumW   = 10;
  localparam int unsigned SymW   = 7;
  localparam int unsigned Steps  = 12;
  localparam int unsigned StepW  = 4;
  localparam logic [NumW-1:0] MaxValid = NumW'(999);

  localparam logic [SymW-1:0] ChNone = 7'h00;
  localparam logic [SymW-1:0] ChI    = 7'h49;
  localparam logic [SymW-1:0] ChV    = 7'h56;
  localparam logic [SymW-1:0] ChX    = 7'h58;
  localparam logic [SymW-1:0] ChL    = 7'h4C;
  localparam logic [SymW-1:0] ChC    = 7'h43;
  localparam logic [SymW-1:0] ChD    = 7'h44;
  localparam logic [SymW-1:0] ChM    = 7'h4D;

  // Classified request passed from front to back.
  typedef struct packed {
    logic            err;
    logic [NumW-1:0] value;
  } item_t;

  // Queue head as seen by the back end.
  typedef struct packed {
    logic  valid;
    item_t item;
  } head_t;

  // One greedy step: threshold, first letter, optional second letter.
  typedef struct packed {
    logic [NumW-1:0] value;
    logic [SymW-1:0] first;
    logic [SymW-1:0] second;
  } step_t;

  function automatic step_t step_lookup(input logic [StepW-1:0] idx);
    step_t s;
    unique case (idx)
      4'd0:    s = '{value: NumW'(900), first: ChC, second: ChM};
      4'd1:    s = '{value: NumW'(500), first: ChD, second: ChNone};
      4'd2:    s = '{value: NumW'(400), first: ChC, second: ChD};
      4'd3:    s = '{value: NumW'(100), first: ChC, second: ChNone};
      4'd4:    s = '{value: NumW'(90),  first: ChX, second: ChC};
      4'd5:    s = '{value: NumW'(50),  first: ChL, second: ChNone};
      4'd6:    s = '{value: NumW'(40),  first: ChX, second: ChL};
      4'd7:    s = '{value: NumW'(10),  first: ChX, second: ChNone};
      4'd8:    s = '{value: NumW'(9),   first: ChI, second: ChX};
      4'd9:    s = '{value: NumW'(5),   first: ChV, second: ChNone};
      4'd10:   s = '{value: NumW'(4),   first: ChI, second: ChV};
      4'd11:   s = '{value: NumW'(1),   first: ChI, second: ChNone};
      default: s = '{value: NumW'(1),   first: ChI, second: ChNone};
    endcase
    return s;
  endfunction

endpackage

>>> rtl/i2r_front.sv
// Front end of the Roman numeral converter: accepts numbers, flags
// out-of-range values and buffers them in a two-entry queue.
// Depends on i2r_pkg.
module i2r_front import i2r_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  logic [NumW-1:0] number_i,
  output head_t           head_o,
  input  logic            pop_i
);

  item_t      mem_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] count_q, count_d;
  logic       push;
  item_t      item_in;

  assign in_stall_o = (count_q == 2'd2);
  assign push       = in_valid_i && !in_stall_o;

  // zero or above 999 is an error request
  assign item_in.err   = (number_i == '0) || (number_i > MaxValid);
  assign item_in.value = number_i;

  assign head_o.valid = (count_q != 2'd0);
  assign head_o.item  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push  ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop_i ? ~rd_ptr_q : rd_ptr_q;
    count_d  = count_q;
    if (push && !pop_i) begin
      count_d = count_q + 2'd1;
    end else if (!push && pop_i) begin
      count_d = count_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= item_in;
    end
  end

endmodule

>>> rtl/i2r_back.sv
// Back end of the Roman numeral converter: emits one letter per cycle while
// not stalled, by greedy subtraction into a registered output stage; an
// error number gives one out-of-range item. Depends on i2r_pkg.
module i2r_back import i2r_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  head_t           head_i,
  output logic            pop_o,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output logic [SymW-1:0] symbol_o,
  output logic            last_o,
  output logic            out_of_range_o
);

  logic            active_q, active_d;
  logic [NumW-1:0] rest_q, rest_d;
  logic [SymW-1:0] sec_q, sec_d;
  logic            out_valid_q, out_valid_d;
  logic [SymW-1:0] symbol_q, symbol_d;
  logic            last_q, last_d;
  logic            oor_q, oor_d;

  logic            emit;
  logic [NumW-1:0] src;
  logic [StepW-1:0] sel;
  step_t           step;
  logic [NumW-1:0] new_rest;

  assign emit  = (active_q || head_i.valid) && (!out_valid_q || !out_stall_i);
  assign pop_o = emit && !active_q;
  assign src   = active_q ? rest_q : head_i.item.value;

  // largest threshold not above the remaining value
  always_comb begin
    step_t cand;
    sel = StepW'(Steps - 1);
    for (int i = Steps - 1; i >= 0; i--) begin
      cand = step_lookup(StepW'(i));
      if (src >= cand.value) begin
        sel = StepW'(i);
      end
    end
  end

  assign step     = step_lookup(sel);
  assign new_rest = src - step.value;

  always_comb begin
    active_d    = active_q;
    rest_d      = rest_q;
    sec_d       = sec_q;
    out_valid_d = out_valid_q && out_stall_i;
    symbol_d    = symbol_q;
    last_d      = last_q;
    oor_d       = oor_q;
    if (emit) begin
      out_valid_d = 1'b1;
      oor_d       = 1'b0;
      if (active_q && sec_q != ChNone) begin
        // second letter of a subtractive pair; rest already reduced
        symbol_d = sec_q;
        last_d   = (rest_q == '0);
        sec_d    = ChNone;
        active_d = (rest_q != '0);
      end else if (!active_q && head_i.item.err) begin
        symbol_d = ChNone;
        last_d   = 1'b1;
        oor_d    = 1'b1;
        active_d = 1'b0;
      end else begin
        symbol_d = step.first;
        sec_d    = step.second;
        rest_d   = new_rest;
        last_d   = (step.second == ChNone) && (new_rest == '0);
        active_d = !last_d;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q    <= 1'b0;
      out_valid_q <= 1'b0;
      sec_q       <= ChNone;
    end else begin
      active_q    <= active_d;
      out_valid_q <= out_valid_d;
      sec_q       <= sec_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rest_q   <= rest_d;
    symbol_q <= symbol_d;
    last_q   <= last_d;
    oor_q    <= oor_d;
  end

  assign out_valid_o    = out_valid_q;
  assign symbol_o       = symbol_q;
  assign last_o         = last_q;
  assign out_of_range_o = oor_q;

endmodule

>>> rtl/integer_to_roman_numeral.sv
// Integer to Roman numeral converter. Each request carries a 10-bit number;
// the block answers with its numeral as ASCII letters, most significant
// first, one letter per output request, with last set on the final letter.
// Numbers 0 and 1000..1023 give one output request with symbol 0, last 1
// and out_of_range 1. A valid number gives 1 to 12 letters, twelve for 888.
// The letter sequencer in the back end emits one character per cycle while
// the output is not stalled. A two-entry queue lets the front take new
// numbers while a run is emitted, and the back end pops the next number
// once it has emitted the previous run's last letter.
// Depends on i2r_pkg, i2r_front and i2r_back.
module integer_to_roman_numeral import i2r_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  logic [NumW-1:0] number_i,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output logic [SymW-1:0] symbol_o,
  output logic            last_o,
  output logic            out_of_range_o
);

  head_t head;
  logic  pop;

  // front: classify and queue
  i2r_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .number_i   (number_i),
    .head_o     (head),
    .pop_i      (pop)
  );

  // back: one letter per cycle into the output register while not stalled
  i2r_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .head_i         (head),
    .pop_o          (pop),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .symbol_o       (symbol_o),
    .last_o         (last_o),
    .out_of_range_o (out_of_range_o)
  );

  // error requests are always a single terminal item with no letter
  a_err_shape: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_of_range_o |-> last_o && symbol_o == ChNone)
    else $error("error item malformed");

  // valid runs always carry a letter
  a_letter: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_of_range_o |-> symbol_o != ChNone)
    else $error("empty letter in run");

  // never pop an empty queue
  a_pop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> head.valid)
    else $error("pop from empty queue");

  // a non-last letter is always followed by more of the same run
  a_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i && !last_o |=> out_valid_o && !out_of_range_o)
    else $error("run broken");

endmodule
